FILE: src/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types and constants for the context token lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package clt_pkg;

  localparam int unsigned POS_W = 20;
  localparam int unsigned LEN_W = 16;
  localparam int unsigned KIND_W = 5;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // token kinds
  localparam logic [KIND_W-1:0] KIND_INT       = 5'd0;
  localparam logic [KIND_W-1:0] KIND_ADD       = 5'd1;
  localparam logic [KIND_W-1:0] KIND_MINUS     = 5'd2;
  localparam logic [KIND_W-1:0] KIND_MUL       = 5'd3;
  localparam logic [KIND_W-1:0] KIND_DIV       = 5'd4;
  localparam logic [KIND_W-1:0] KIND_ASSIGN    = 5'd5;
  localparam logic [KIND_W-1:0] KIND_LPAREN    = 5'd6;
  localparam logic [KIND_W-1:0] KIND_RPAREN    = 5'd7;
  localparam logic [KIND_W-1:0] KIND_LBRACE    = 5'd8;
  localparam logic [KIND_W-1:0] KIND_RBRACE    = 5'd9;
  localparam logic [KIND_W-1:0] KIND_SEMI      = 5'd10;
  localparam logic [KIND_W-1:0] KIND_TYPE      = 5'd11;
  localparam logic [KIND_W-1:0] KIND_PROCDECL  = 5'd12;
  localparam logic [KIND_W-1:0] KIND_CALL      = 5'd13;
  localparam logic [KIND_W-1:0] KIND_DECLCHILD = 5'd14;
  localparam logic [KIND_W-1:0] KIND_IDENT_L   = 5'd15;
  localparam logic [KIND_W-1:0] KIND_IDENT_R   = 5'd16;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  start;
    logic [LEN_W-1:0]  length;
    logic              run_last;
  } token_t;

  // results of one byte, in order; count is 0 to 2
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } step_res_t;

endpackage

`default_nettype wire

FILE: src/clt_in_if.sv
// ----------------------------------------------------------------------------
// clt_in_if
// Byte channel into the lexer.
// ----------------------------------------------------------------------------
`default_nettype none

interface clt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

`default_nettype wire

FILE: src/clt_out_if.sv
// ----------------------------------------------------------------------------
// clt_out_if
// Token channel out of the lexer.
// ----------------------------------------------------------------------------
`default_nettype none

interface clt_out_if;
  import clt_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] token_kind;
  logic [POS_W-1:0]  token_start;
  logic [LEN_W-1:0]  token_length;
  logic              run_last;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output run_last, input ready);
  modport sink (input valid, input token_kind, input token_start,
                input token_length, input run_last, output ready);
endinterface

`default_nettype wire

FILE: src/clt_core.sv
// ----------------------------------------------------------------------------
// clt_core
// Lexer state and the single-pass step logic for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module clt_core
  import clt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       take,
  input  wire logic [7:0] char_code,
  input  wire logic       end_of_text,
  output step_res_t       res
);

  localparam logic [1:0] PC_NONE  = 2'd0;
  localparam logic [1:0] PC_INT   = 2'd1;
  localparam logic [1:0] PC_IDENT = 2'd2;

  localparam logic [2:0] KP_START = 3'd0;
  localparam logic [2:0] KP_I     = 3'd1;
  localparam logic [2:0] KP_IN    = 3'd2;
  localparam logic [2:0] KP_INT   = 3'd3;
  localparam logic [2:0] KP_MISS  = 3'd4;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_MUL    = 8'h2A;
  localparam logic [7:0] CH_ADD    = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DIV    = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_ASSIGN = 8'h3D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_I      = 8'h69;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;

  typedef struct packed {
    logic        elv;
    logic        idl;
    logic [15:0] pcount;
  } flags_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    flags_t            f;
  } cls_t;

  function automatic cls_t classify(input logic [1:0] pc, input logic [2:0] kp,
                                    input logic nlp, input flags_t fi);
    cls_t r;
    r.f = fi;
    if (pc == PC_INT) begin
      r.kind = KIND_INT;
    end else if (kp == KP_INT) begin
      r.kind = KIND_TYPE;
      r.f.idl = 1'b1;
      r.f.elv = 1'b1;
    end else if (nlp && fi.idl) begin
      r.kind = KIND_PROCDECL;
      r.f.idl = 1'b0;
    end else if (nlp) begin
      r.kind = KIND_CALL;
      r.f.elv = 1'b0;
      r.f.pcount = '0;
    end else if (fi.elv && fi.idl) begin
      r.kind = KIND_DECLCHILD;
      r.f.elv = 1'b0;
      r.f.idl = 1'b0;
    end else if (fi.elv) begin
      r.kind = KIND_IDENT_L;
      r.f.elv = 1'b0;
    end else begin
      r.kind = KIND_IDENT_R;
    end
    return r;
  endfunction

  logic [1:0]       pending_class, pc_next;
  logic [POS_W-1:0] pending_start, ps_next;
  logic [LEN_W-1:0] pending_length, pl_next;
  logic [2:0]       keyword_progress, kp_next;
  flags_t           flags, flags_next;
  logic [POS_W-1:0] byte_position;

  logic   is_dig, is_let, consumed;
  logic   emit_a, emit_b, emit_c;
  token_t tok_a, tok_b, tok_c;
  cls_t   cls_a, cls_c;
  flags_t flags_a;
  logic [1:0] pc_b;
  logic [POS_W-1:0] ps_b;
  logic [LEN_W-1:0] pl_b;
  logic [2:0] kp_b;

  always_comb begin
    is_dig = (char_code >= 8'h30) && (char_code <= 8'h39);
    is_let = ((char_code >= 8'h61) && (char_code <= 8'h7A)) ||
             ((char_code >= 8'h41) && (char_code <= 8'h5A));
    consumed = ((pending_class == PC_INT) && is_dig) ||
               ((pending_class == PC_IDENT) && (is_let || is_dig || char_code == CH_UNDER));

    // flush of the pending token ahead of this byte
    emit_a  = !consumed && (pending_class != PC_NONE);
    cls_a   = classify(pending_class, keyword_progress, char_code == CH_LPAREN, flags);
    flags_a = emit_a ? cls_a.f : flags;
    tok_a   = '{kind: cls_a.kind, start: pending_start, length: pending_length,
                run_last: 1'b0};

    // pending token and single-character token after this byte
    pc_b = pending_class;
    ps_b = pending_start;
    pl_b = pending_length;
    kp_b = keyword_progress;
    flags_next = flags_a;
    emit_b = 1'b0;
    tok_b = '{kind: KIND_ADD, start: byte_position, length: LEN_W'(1), run_last: 1'b0};
    if (consumed) begin
      if (pending_class == PC_IDENT) begin
        if (keyword_progress == KP_I && char_code == CH_N) begin
          kp_b = KP_IN;
        end else if (keyword_progress == KP_IN && char_code == CH_T) begin
          kp_b = KP_INT;
        end else begin
          kp_b = KP_MISS;
        end
      end
      if (pending_length != LEN_MAX) begin
        pl_b = pending_length + LEN_W'(1);
      end
    end else if (is_dig) begin
      pc_b = PC_INT;
      ps_b = byte_position;
      pl_b = LEN_W'(1);
      kp_b = KP_START;
    end else if (is_let) begin
      pc_b = PC_IDENT;
      ps_b = byte_position;
      pl_b = LEN_W'(1);
      kp_b = (char_code == CH_I) ? KP_I : KP_MISS;
    end else begin
      pc_b = PC_NONE;
      ps_b = '0;
      pl_b = '0;
      kp_b = KP_START;
      case (char_code)
        CH_ADD: begin
          emit_b = 1'b1;
          tok_b.kind = KIND_ADD;
        end
        CH_MINUS: begin
          emit_b = 1'b1;
          tok_b.kind = KIND_MINUS;
        end
        CH_MUL: begin
          emit_b = 1'b1;
          tok_b.kind = KIND_MUL;
        end
        CH_DIV: begin
          emit_b = 1'b1;
          tok_b.kind = KIND_DIV;
        end
        CH_ASSIGN: begin
          emit_b = 1'b1;
          tok_b.kind = KIND_ASSIGN;
        end
        CH_LPAREN: begin
          flags_next.pcount = flags_a.pcount + 16'd1;
          emit_b = (flags_next.pcount != 16'd1);
          tok_b.kind = KIND_LPAREN;
        end
        CH_RPAREN: begin
          flags_next.pcount = flags_a.pcount - 16'd1;
          emit_b = (flags_next.pcount != 16'd0);
          tok_b.kind = KIND_RPAREN;
        end
        CH_LBRACE: begin
          emit_b = 1'b1;
          tok_b.kind = KIND_LBRACE;
        end
        CH_RBRACE: begin
          emit_b = 1'b1;
          tok_b.kind = KIND_RBRACE;
        end
        CH_SEMI: begin
          emit_b = 1'b1;
          tok_b.kind = KIND_SEMI;
          flags_next.elv = 1'b1;
        end
        default: begin
          emit_b = 1'b0;
        end
      endcase
    end

    // end-of-text flush
    emit_c = end_of_text && (pc_b != PC_NONE);
    cls_c  = classify(pc_b, kp_b, 1'b0, flags_next);
    tok_c  = '{kind: cls_c.kind, start: ps_b, length: pl_b, run_last: 1'b0};
    pc_next = pc_b;
    ps_next = ps_b;
    pl_next = pl_b;
    kp_next = kp_b;
    if (emit_c) begin
      flags_next = cls_c.f;
      pc_next = PC_NONE;
      ps_next = '0;
      pl_next = '0;
      kp_next = KP_START;
    end

    // pack results in order; at most two of the three fire
    res.count = 2'({1'b0, emit_a} + {1'b0, emit_b} + {1'b0, emit_c});
    res.tok0 = emit_a ? tok_a : (emit_b ? tok_b : tok_c);
    res.tok1 = (emit_a && emit_b) ? tok_b : tok_c;
    res.tok0.run_last = (res.count == 2'd1);
    res.tok1.run_last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_class    <= PC_NONE;
      pending_start    <= '0;
      pending_length   <= '0;
      keyword_progress <= KP_START;
      flags            <= '{elv: 1'b1, idl: 1'b0, pcount: 16'd1};
      byte_position    <= '0;
    end else if (take) begin
      pending_class    <= pc_next;
      pending_start    <= ps_next;
      pending_length   <= pl_next;
      keyword_progress <= kp_next;
      flags            <= flags_next;
      byte_position    <= byte_position + POS_W'(1);
    end
  end

endmodule

`default_nettype wire

FILE: src/clt_out_buf.sv
// ----------------------------------------------------------------------------
// clt_out_buf
// Two-slot result register holding the tokens of one byte until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module clt_out_buf
  import clt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      load,
  input  wire step_res_t res,
  output logic           space,
  clt_out_if.source      tokens
);

  token_t     slot0, slot1;
  logic [1:0] cnt;
  logic       pop;

  assign pop    = tokens.valid && tokens.ready;
  assign space  = (cnt == 2'd0) || ((cnt == 2'd1) && pop);

  assign tokens.valid        = (cnt != 2'd0);
  assign tokens.token_kind   = slot0.kind;
  assign tokens.token_start  = slot0.start;
  assign tokens.token_length = slot0.length;
  assign tokens.run_last     = slot0.run_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= res.count;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot0 <= res.tok0;
      slot1 <= res.tok1;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

endmodule

`default_nettype wire

FILE: src/context_token_lexer.sv
// ----------------------------------------------------------------------------
// context_token_lexer
// Streaming lexer: one source byte per transfer in, tokens out.
//
//   channel  dir  payload
//   text     in   char_code[7:0], end_of_text
//   tokens   out  token_kind[4:0], token_start[19:0], token_length[15:0], run_last
//
// One byte is taken per cycle while the result register has space; its tokens
// (zero to two) are computed in the same cycle from the lexer state and land in
// a two-slot result register. A byte that gives two tokens holds text.ready low
// while the first token drains. Reset is synchronous and resets all lexer state;
// tokens.ready low stalls the result register and then the input.
// ----------------------------------------------------------------------------
`default_nettype none

module context_token_lexer
  import clt_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  clt_in_if.sink    text,
  clt_out_if.source tokens
);

  step_res_t res;
  logic      space;
  logic      take;

  assign text.ready = space;
  assign take       = text.valid && space;

  clt_core u_core (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .char_code   (text.char_code),
    .end_of_text (text.end_of_text),
    .res         (res)
  );

  clt_out_buf u_out_buf (
    .clk    (clk),
    .rst    (rst),
    .load   (take),
    .res    (res),
    .space  (space),
    .tokens (tokens)
  );

  a_pair_first_not_last : assert property (@(posedge clk) disable iff (rst)
    take && (res.count == 2'd2) |=> tokens.valid && !tokens.run_last)
    else $error("first of two tokens flagged as last");

  a_hold_while_pair : assert property (@(posedge clk) disable iff (rst)
    tokens.valid && !tokens.run_last |-> !text.ready)
    else $error("input taken while second token pending");

  a_result_shows : assert property (@(posedge clk) disable iff (rst)
    take && (res.count != 2'd0) |=> tokens.valid)
    else $error("token lost after transfer");

endmodule

`default_nettype wire
